>>> sv/vcc_pkg.sv
// ----------------------------------------------------------------------------
// vcc_pkg: shared types, constants and helpers of the connectivity classifier
// Holds the controller state and phase enums, the command and status bundles
// between controller and datapath, the class codes and bit-mask helpers.
// ----------------------------------------------------------------------------
package vcc_pkg;

  // Vertex indexes are five bits wide and adjacency rows 32 bits wide.
  localparam int VTX_W = 5;
  localparam int ROW_W = 32;
  // Vertex counts need one bit more so that a full graph of 32 fits.
  localparam int CNT_W = 6;

  localparam logic [1:0] CLS_DISCONNECTED = 2'd0;
  localparam logic [1:0] CLS_CUT_VERTEX   = 2'd1;
  localparam logic [1:0] CLS_SEP_PAIR     = 2'd2;
  localparam logic [1:0] CLS_THREE_PLUS   = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_PICK,
    ST_MERGE
  } vcc_state_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WHOLE,
    PH_SINGLE,
    PH_PAIR
  } vcc_phase_e;

  typedef struct packed {
    logic       accept;      // request taken: store its row
    logic       init;        // capture vertex count and full mask
    logic       begin_test;  // load the allowed set and the seed vertex
    logic       rm_first;    // remove vertex i in this test
    logic       rm_second;   // remove vertex j in this test
    logic       issue_read;  // read the row of the lowest unexpanded vertex
    logic       merge;       // fold the row just read into the reached set
    logic       clr_i;       // i = 0
    logic       inc_i;       // i = i + 1
    logic       pair_init;   // i = 0, j = 1
    logic       inc_j;       // j = j + 1
    logic       next_pair;   // i = i + 1, j = i + 2
    logic       emit;        // present a result
    logic [1:0] cls;         // class of that result
  } vcc_cmd_t;

  typedef struct packed {
    logic frontier_empty;  // every reached vertex has been expanded
    logic connected;       // reached set equals allowed set
    logic n_zero;          // no vertices at all
    logic n_lt2;           // fewer than two vertices: no pairs
    logic i_last_single;   // i is the last vertex
    logic j_last;          // j is the last vertex
    logic i_last_pair;     // no pair starts after i
  } vcc_status_t;

  // Index of the lowest set bit; zero when no bit is set.
  function automatic logic [VTX_W-1:0] lowest_index(input logic [ROW_W-1:0] x);
    logic [VTX_W-1:0] idx;
    idx = '0;
    for (int k = ROW_W - 1; k >= 0; k--) begin
      if (x[k]) begin
        idx = VTX_W'(k);
      end
    end
    return idx;
  endfunction

  // Mask of the vertices 0 .. n-1.
  function automatic logic [ROW_W-1:0] vertex_mask(input logic [CNT_W-1:0] n);
    logic [ROW_W-1:0] m;
    if (n >= CNT_W'(ROW_W)) begin
      m = '1;
    end else begin
      m = (ROW_W'(1) << n[VTX_W-1:0]) - ROW_W'(1);
    end
    return m;
  endfunction

endpackage

>>> sv/vcc_datapath.sv
// ----------------------------------------------------------------------------
// vcc_datapath: adjacency memory, reachability closure and result register
// Stores the rows, walks the reached set one vertex at a time, reading its row
// and then merging it, and keeps the removal counters and the registered result.
// ----------------------------------------------------------------------------
module vcc_datapath
  import vcc_pkg::*;
#(
  parameter int RowLimit = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vcc_cmd_t            cmd_i,
  output vcc_status_t         status_o,
  input  logic [CNT_W-1:0]    vertex_count_i,
  input  logic [VTX_W-1:0]    row_index_i,
  input  logic [ROW_W-1:0]    row_bits_i,
  output logic                result_strobe_o,
  output logic [1:0]          connectivity_class_o,
  output logic                exactly_two_o
);

  localparam int AddrW = $clog2(RowLimit);

  logic [ROW_W-1:0] mem_q [RowLimit];
  logic [ROW_W-1:0] rd_q;

  logic [CNT_W-1:0] n_q;
  logic [ROW_W-1:0] all_q;
  logic [VTX_W-1:0] i_q, j_q;
  logic [ROW_W-1:0] allowed_q, seen_q, expanded_q;
  logic             strobe_q;
  logic [1:0]       cls_q;

  logic [CNT_W-1:0] n_sat;
  logic [ROW_W-1:0] frontier;
  logic [VTX_W-1:0] pick_idx;
  logic [ROW_W-1:0] rm_mask;
  logic [ROW_W-1:0] allowed_d;

  assign n_sat = (vertex_count_i > CNT_W'(RowLimit)) ? CNT_W'(RowLimit) : vertex_count_i;

  assign frontier = seen_q & ~expanded_q;
  assign pick_idx = lowest_index(frontier);

  always_comb begin
    rm_mask = '0;
    if (cmd_i.rm_first) begin
      rm_mask = rm_mask | (ROW_W'(1) << i_q);
    end
    if (cmd_i.rm_second) begin
      rm_mask = rm_mask | (ROW_W'(1) << j_q);
    end
    allowed_d = all_q & ~rm_mask;
  end

  // Row storage: written on an accepted request, read one row at a time.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && ({1'b0, row_index_i} < CNT_W'(RowLimit))) begin
      mem_q[row_index_i[AddrW-1:0]] <= row_bits_i;
    end
    if (cmd_i.issue_read) begin
      rd_q <= mem_q[pick_idx[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      n_q   <= n_sat;
      all_q <= vertex_mask(n_sat);
    end
    if (cmd_i.clr_i) begin
      i_q <= '0;
    end else if (cmd_i.inc_i) begin
      i_q <= i_q + VTX_W'(1);
    end else if (cmd_i.pair_init) begin
      i_q <= '0;
      j_q <= VTX_W'(1);
    end else if (cmd_i.inc_j) begin
      j_q <= j_q + VTX_W'(1);
    end else if (cmd_i.next_pair) begin
      i_q <= i_q + VTX_W'(1);
      j_q <= i_q + VTX_W'(2);
    end
    if (cmd_i.begin_test) begin
      allowed_q  <= allowed_d;
      // Seed the closure with the lowest remaining vertex.
      seen_q     <= allowed_d & (~allowed_d + ROW_W'(1));
      expanded_q <= '0;
    end else if (cmd_i.issue_read) begin
      expanded_q <= expanded_q | (ROW_W'(1) << pick_idx);
    end else if (cmd_i.merge) begin
      seen_q <= seen_q | (rd_q & allowed_q);
    end
    if (cmd_i.emit) begin
      cls_q <= cmd_i.cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.emit;
    end
  end

  always_comb begin
    status_o.frontier_empty = (frontier == '0);
    status_o.connected      = (seen_q == allowed_q);
    status_o.n_zero         = (n_q == '0);
    status_o.n_lt2          = (n_q < CNT_W'(2));
    status_o.i_last_single  = ({1'b0, i_q} + CNT_W'(1)) >= n_q;
    status_o.j_last         = ({1'b0, j_q} + CNT_W'(1)) >= n_q;
    status_o.i_last_pair    = ({1'b0, i_q} + CNT_W'(2)) >= n_q;
  end

  assign result_strobe_o      = strobe_q;
  assign connectivity_class_o = cls_q;
  assign exactly_two_o        = (cls_q == CLS_SEP_PAIR);

endmodule

>>> sv/vcc_ctrl.sv
// ----------------------------------------------------------------------------
// vcc_ctrl: sequencing of the connectivity tests
// Runs the whole-graph test, then single removals, then pair removals, and
// stops at the first test that leaves the remaining vertices disconnected or after the last test.
// ----------------------------------------------------------------------------
module vcc_ctrl
  import vcc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        last_row_i,
  input  vcc_status_t status_i,
  output logic        busy,
  output vcc_cmd_t    cmd_o
);

  vcc_state_e state_q, state_d;
  vcc_phase_e phase_q, phase_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_IDLE;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  // Next state and phase.
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start && last_row_i) begin
          state_d = ST_START;
          phase_d = PH_WHOLE;
        end
      end
      ST_START: begin
        state_d = ST_PICK;
      end
      ST_PICK: begin
        if (!status_i.frontier_empty) begin
          state_d = ST_MERGE;
        end else if (!status_i.connected) begin
          state_d = ST_IDLE;
          phase_d = PH_IDLE;
        end else begin
          unique case (phase_q)
            PH_WHOLE: begin
              if (status_i.n_zero) begin
                state_d = ST_IDLE;
                phase_d = PH_IDLE;
              end else begin
                state_d = ST_START;
                phase_d = PH_SINGLE;
              end
            end
            PH_SINGLE: begin
              if (!status_i.i_last_single) begin
                state_d = ST_START;
              end else if (status_i.n_lt2) begin
                state_d = ST_IDLE;
                phase_d = PH_IDLE;
              end else begin
                state_d = ST_START;
                phase_d = PH_PAIR;
              end
            end
            PH_PAIR: begin
              if (!status_i.j_last || !status_i.i_last_pair) begin
                state_d = ST_START;
              end else begin
                state_d = ST_IDLE;
                phase_d = PH_IDLE;
              end
            end
            default: begin
              state_d = ST_IDLE;
              phase_d = PH_IDLE;
            end
          endcase
        end
      end
      ST_MERGE: begin
        state_d = ST_PICK;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.accept = start;
        cmd_o.init   = start && last_row_i;
      end
      ST_START: begin
        cmd_o.begin_test = 1'b1;
        cmd_o.rm_first   = (phase_q == PH_SINGLE) || (phase_q == PH_PAIR);
        cmd_o.rm_second  = (phase_q == PH_PAIR);
      end
      ST_PICK: begin
        if (!status_i.frontier_empty) begin
          cmd_o.issue_read = 1'b1;
        end else if (!status_i.connected) begin
          cmd_o.emit = 1'b1;
          unique case (phase_q)
            PH_WHOLE:  cmd_o.cls = CLS_DISCONNECTED;
            PH_SINGLE: cmd_o.cls = CLS_CUT_VERTEX;
            PH_PAIR:   cmd_o.cls = CLS_SEP_PAIR;
            default:   cmd_o.cls = CLS_THREE_PLUS;
          endcase
        end else begin
          unique case (phase_q)
            PH_WHOLE: begin
              if (status_i.n_zero) begin
                cmd_o.emit = 1'b1;
                cmd_o.cls  = CLS_THREE_PLUS;
              end else begin
                cmd_o.clr_i = 1'b1;
              end
            end
            PH_SINGLE: begin
              if (!status_i.i_last_single) begin
                cmd_o.inc_i = 1'b1;
              end else if (status_i.n_lt2) begin
                cmd_o.emit = 1'b1;
                cmd_o.cls  = CLS_THREE_PLUS;
              end else begin
                cmd_o.pair_init = 1'b1;
              end
            end
            PH_PAIR: begin
              if (!status_i.j_last) begin
                cmd_o.inc_j = 1'b1;
              end else if (!status_i.i_last_pair) begin
                cmd_o.next_pair = 1'b1;
              end else begin
                cmd_o.emit = 1'b1;
                cmd_o.cls  = CLS_THREE_PLUS;
              end
            end
            default: begin
              cmd_o.emit = 1'b1;
              cmd_o.cls  = CLS_THREE_PLUS;
            end
          endcase
        end
      end
      ST_MERGE: begin
        cmd_o.merge = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  assign busy = (state_q != ST_IDLE);

  // Every merge state must be entered from the pick state, where its row read is issued.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MERGE |-> $past(state_q) == ST_PICK)
    else $error("merge without a preceding row read");

  // Tests only run while a classification phase is active.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (phase_q != PH_IDLE))
    else $error("controller busy without an active phase");

endmodule

>>> sv/vertex_connectivity_classifier.sv
// ----------------------------------------------------------------------------
// vertex_connectivity_classifier: brute-force vertex connectivity of a graph
// Loads adjacency rows one request at a time and classifies the graph when
// the request marked as the last row arrives.
// ----------------------------------------------------------------------------
// Usage. A request is taken at a rising edge with start high and busy low.
// Each request carries one adjacency row (row_index_i, row_bits_i) and the
// vertex count. Rows with an index at or above the supported vertex count
// are dropped. A request without last_row_i leaves busy low, so rows can be
// streamed one per cycle.
// A request with last_row_i stores its row and then raises busy while the
// classifier runs: first the whole graph, then every single vertex removed,
// then every pair removed, stopping at the first test that disconnects the
// remaining vertices. Each test walks the reached set, reading one row from
// the adjacency memory per expanded vertex. A graph of n vertices needs at
// most 1 + n + n*(n-1)/2 tests. The result (connectivity_class_o,
// exactly_two_o) is shown for exactly one cycle with result_strobe_o, in the
// first cycle in which busy is low again; the receiver cannot hold it off.
// Reset clears the controller and the strobe; the row memory keeps no reset
// and every row a classification reads must be loaded first.
// ----------------------------------------------------------------------------
module vertex_connectivity_classifier
  import vcc_pkg::*;
#(
  parameter int MAX_VERTICES = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [CNT_W-1:0]    vertex_count_i,
  input  logic [VTX_W-1:0]    row_index_i,
  input  logic [ROW_W-1:0]    row_bits_i,
  input  logic                last_row_i,
  output logic                result_strobe_o,
  output logic [1:0]          connectivity_class_o,
  output logic                exactly_two_o
);

  // Rows are 32 bits, so no more than 32 vertices can be addressed.
  localparam int RowLimit = (MAX_VERTICES < ROW_W) ? MAX_VERTICES : ROW_W;

  vcc_cmd_t    cmd;
  vcc_status_t status;

  vcc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .last_row_i (last_row_i),
    .status_i   (status),
    .busy       (busy),
    .cmd_o      (cmd)
  );

  vcc_datapath #(
    .RowLimit (RowLimit)
  ) u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .status_o             (status),
    .vertex_count_i       (vertex_count_i),
    .row_index_i          (row_index_i),
    .row_bits_i           (row_bits_i),
    .result_strobe_o      (result_strobe_o),
    .connectivity_class_o (connectivity_class_o),
    .exactly_two_o        (exactly_two_o)
  );

  // A plain row load leaves the block free in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && !last_row_i |=> !busy && !result_strobe_o)
    else $error("row load occupied the block");

  // The last row starts a classification.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && last_row_i |=> busy)
    else $error("last row did not start classification");

  // A result appears only right after a classification finished.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> !busy && $past(busy))
    else $error("result outside the end of a classification");

endmodule
